/* rtl/dimmer_blind_switch_state_machine_core_assert.svh */
// Assertion macros used by the checker file of the device controller
`ifndef DIMMER_BLIND_SWITCH_STATE_MACHINE_CORE_ASSERT_SVH
`define DIMMER_BLIND_SWITCH_STATE_MACHINE_CORE_ASSERT_SVH

// same-cycle implication
`define DBSSM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dbssm: assertion failed");

// next-cycle implication
`define DBSSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dbssm: assertion failed");

`endif

/* rtl/dbssm_pkg.sv */
// Shared types and constants of the device controller
package dbssm_pkg;

   localparam int OUTPUT_SLOTS = 8;

   localparam logic [2:0] KIND_SWITCH = 3'd0;
   localparam logic [2:0] KIND_LIGHT  = 3'd1;
   localparam logic [2:0] KIND_DIMMER = 3'd2;
   localparam logic [2:0] KIND_BLIND  = 3'd3;
   localparam logic [2:0] KIND_HANDLE = 3'd4;

   localparam logic [1:0] OP_SET   = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [2:0] CSR_DEVICE_KIND   = 3'd0;
   localparam logic [2:0] CSR_DELAY_TICKS   = 3'd1;
   localparam logic [2:0] CSR_TIMEOUT_TICKS = 3'd2;
   localparam logic [2:0] CSR_RAMP_SPEED    = 3'd3;
   localparam logic [2:0] CSR_OUTPUT_SLOT   = 3'd4;

   localparam logic [6:0] ST_OFF      = 7'd0;
   localparam logic [6:0] ST_ON       = 7'd100;
   localparam logic [6:0] ST_STOP     = 7'd101;
   localparam logic [6:0] ST_DIM      = 7'd102;
   localparam logic [6:0] ST_LIGHTEN  = 7'd103;
   localparam logic [6:0] ST_DARKEN   = 7'd104;
   localparam logic [6:0] ST_LOCKED   = 7'd105;
   localparam logic [6:0] ST_CLOSED   = 7'd106;
   localparam logic [6:0] ST_OPEN     = 7'd107;
   localparam logic [6:0] ST_TILT     = 7'd108;
   localparam logic [6:0] ST_SHUT     = 7'd109;
   localparam logic [6:0] ST_UNSHUT   = 7'd110;
   localparam logic [6:0] ST_UNLOCKED = 7'd111;

   typedef struct packed {
      logic [2:0]  device_kind;
      logic [23:0] delay_ticks;
      logic [23:0] timeout_ticks;
      logic [15:0] ramp_speed;
      logic [3:0]  output_slot;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [6:0]  state_code;
      logic [15:0] elapsed_ticks;
   } req_item_type;

   typedef struct packed {
      logic [8:0] drive_mask;
      logic       is_active;
      logic [6:0] level_now;
   } rsp_item_type;

endpackage

/* rtl/dimmer_blind_switch_state_machine_core.sv */
// Top level of the single-device controller: request and response registers
//
// Usage:
//   Requests enter on req_valid/req_stall with opcode, state_code and
//   elapsed_ticks; each request yields exactly one response on rsp_valid/
//   rsp_stall carrying drive_mask, is_active and level_now.
//   Configuration registers are written through csr_write_enable, csr_index and
//   csr_wdata by the user only while no request is in flight (not enforced);
//   index 0 device kind, 1 delay ticks, 2 timeout ticks, 3 ramp speed, 4 output slot.
// Timing:
//   A request is captured in the input register at acceptance; the state
//   update then runs and loads the response register, which drives rsp_valid;
//   a stalled response can hold the request in the input register. One request
//   per cycle is sustained while rsp_stall stays low.
// Reset:
//   Synchronous reset empties both registers, clears all configuration
//   and returns the device to off with an idle phase.
// Backpressure:
//   While rsp_stall holds a response, the input register still takes one
//   request; req_stall rises only when both registers are full and stalled.
module dimmer_blind_switch_state_machine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [6:0]  req_state_code,
   input  logic [15:0] req_elapsed_ticks,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_drive_mask,
   output logic        rsp_is_active,
   output logic [6:0]  rsp_level_now,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   dbssm_pkg::cfg_type      cfg;
   dbssm_pkg::req_item_type item_ff, item_in;
   dbssm_pkg::rsp_item_type result, out_ff;
   logic                    in_vld_ff, in_vld_in, out_vld_ff, out_vld_in;
   logic                    take, advance;

   dbssm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   dbssm_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance    = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && out_vld_ff && rsp_stall;
   assign take       = req_valid && !req_stall;
   assign in_vld_in  = take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);

   assign item_in.opcode        = req_opcode;
   assign item_in.state_code    = req_state_code;
   assign item_in.elapsed_ticks = req_elapsed_ticks;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_drive_mask = out_ff.drive_mask;
   assign rsp_is_active  = out_ff.is_active;
   assign rsp_level_now  = out_ff.level_now;

endmodule

/* rtl/dbssm_csr.sv */
// Configuration registers of the device controller
module dbssm_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   output dbssm_pkg::cfg_type cfg
);

   dbssm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            dbssm_pkg::CSR_DEVICE_KIND:   cfg_in.device_kind   = csr_wdata[2:0];
            dbssm_pkg::CSR_DELAY_TICKS:   cfg_in.delay_ticks   = csr_wdata;
            dbssm_pkg::CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata;
            dbssm_pkg::CSR_RAMP_SPEED:    cfg_in.ramp_speed    = csr_wdata[15:0];
            dbssm_pkg::CSR_OUTPUT_SLOT:   cfg_in.output_slot   = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/dbssm_step.sv */
// Device state registers and the combinational command, tick and query logic
module dbssm_step (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  dbssm_pkg::req_item_type item,
   input  dbssm_pkg::cfg_type      cfg,
   output dbssm_pkg::rsp_item_type result
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DELAY = 2'd1,
      PH_RAMP  = 2'd2
   } phase_type;

   logic [6:0]         cur_ff, cur_in, prev_ff, prev_in;
   phase_type          phase_ff, phase_in;
   logic signed [25:0] cnt_ff, cnt_in;

   logic               is_sw, is_ramp, is_handle;
   logic signed [33:0] cnt_wide, tgt_pos, ramp_up, ramp_dn, ramp_pos, dec, round_sum;
   logic [31:0]        step_amt;
   logic signed [25:0] cur_cnt, timeout_cnt, delay_cnt;
   logic [6:0]         round_lvl, dim_tgt, set_tgt, code;
   logic               ramp_rising;
   logic [1:0]         flags;
   logic               act;

   assign code      = item.state_code;
   assign is_sw     = (cfg.device_kind == dbssm_pkg::KIND_SWITCH) ||
                      (cfg.device_kind == dbssm_pkg::KIND_LIGHT);
   assign is_ramp   = (cfg.device_kind == dbssm_pkg::KIND_DIMMER) ||
                      (cfg.device_kind == dbssm_pkg::KIND_BLIND);
   assign is_handle = (cfg.device_kind == dbssm_pkg::KIND_HANDLE);

   assign cnt_wide    = 34'(cnt_ff);
   assign tgt_pos     = signed'({11'd0, cur_ff, 16'd0});
   assign cur_cnt     = signed'({3'd0, cur_ff, 16'd0});
   assign timeout_cnt = signed'({2'd0, cfg.timeout_ticks});
   assign delay_cnt   = signed'({2'd0, cfg.delay_ticks});

   assign step_amt    = {16'd0, item.elapsed_ticks} * {16'd0, cfg.ramp_speed};
   assign ramp_up     = cnt_wide + signed'({2'd0, step_amt});
   assign ramp_dn     = cnt_wide - signed'({2'd0, step_amt});
   assign ramp_rising = cnt_wide < tgt_pos;
   assign ramp_pos    = ramp_rising ? ((ramp_up > tgt_pos) ? tgt_pos : ramp_up)
                                    : ((ramp_dn < tgt_pos) ? tgt_pos : ramp_dn);

   assign dec         = cnt_wide - signed'({18'd0, item.elapsed_ticks});

   assign round_sum   = cnt_wide + 34'sh8000;
   assign round_lvl   = round_sum[33] ? dbssm_pkg::ST_OFF : round_sum[22:16];

   assign dim_tgt = (((prev_ff > cur_ff) && (cur_ff < dbssm_pkg::ST_ON)) ||
                     (cur_ff == dbssm_pkg::ST_OFF)) ? dbssm_pkg::ST_ON : dbssm_pkg::ST_OFF;
   assign set_tgt = (code == dbssm_pkg::ST_DIM)     ? dim_tgt :
                    (code == dbssm_pkg::ST_LIGHTEN) ? dbssm_pkg::ST_ON :
                    (code == dbssm_pkg::ST_DARKEN)  ? dbssm_pkg::ST_OFF : code;

   always_comb begin
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      flags    = 2'd0;
      act      = 1'b0;
      unique case (item.opcode)
         dbssm_pkg::OP_SET: begin
            if (is_sw) begin
               prev_in  = cur_ff;
               cur_in   = code;
               phase_in = PH_DELAY;
               cnt_in   = delay_cnt;
            end else if (is_handle) begin
               prev_in = cur_ff;
               cur_in  = code;
            end else if (is_ramp) begin
               if ((cfg.device_kind == dbssm_pkg::KIND_DIMMER) &&
                   ((code == dbssm_pkg::ST_OFF) || (code == dbssm_pkg::ST_ON))) begin
                  prev_in  = cur_ff;
                  cur_in   = code;
                  phase_in = PH_IDLE;
                  cnt_in   = timeout_cnt;
               end else if ((code == dbssm_pkg::ST_STOP) || (phase_ff == PH_RAMP)) begin
                  if (phase_ff == PH_RAMP) begin
                     cur_in   = round_lvl;
                     phase_in = PH_IDLE;
                  end
               end else begin
                  prev_in  = cur_ff;
                  cur_in   = set_tgt;
                  phase_in = PH_RAMP;
                  cnt_in   = cur_cnt;
               end
            end
         end
         dbssm_pkg::OP_TICK: begin
            if (is_sw) begin
               if (phase_ff == PH_DELAY) begin
                  if (dec <= 34'sd0) begin
                     phase_in = PH_IDLE;
                     cnt_in   = timeout_cnt;
                  end else begin
                     cnt_in = dec[25:0];
                  end
               end else if (cnt_ff > 26'sd0) begin
                  cnt_in = dec[25:0];
                  if (dec <= 34'sd0) begin
                     prev_in = cur_ff;
                     cur_in  = dbssm_pkg::ST_OFF;
                  end
               end
               flags = {1'b0, (((phase_in == PH_DELAY) ? prev_ff : cur_ff) == dbssm_pkg::ST_ON)};
            end else if (is_ramp) begin
               if (phase_ff == PH_RAMP) begin
                  if ((cfg.ramp_speed == 16'd0) || (ramp_pos == tgt_pos)) begin
                     phase_in = PH_IDLE;
                     cnt_in   = timeout_cnt;
                  end else begin
                     cnt_in = ramp_pos[25:0];
                     flags  = ramp_rising ? 2'd1 : 2'd2;
                  end
               end else if (cnt_ff > 26'sd0) begin
                  if (dec <= 34'sd0) begin
                     prev_in = cur_ff;
                     cur_in  = dbssm_pkg::ST_OFF;
                     cnt_in  = cur_cnt;
                  end else begin
                     cnt_in = dec[25:0];
                  end
               end
            end
         end
         dbssm_pkg::OP_QUERY: begin
            if (code == cur_ff) begin
               act = 1'b1;
            end else if (is_ramp) begin
               if (phase_ff == PH_IDLE) begin
                  act = (code == dbssm_pkg::ST_STOP);
               end else begin
                  act = (code == dbssm_pkg::ST_DIM) ||
                        ((code == dbssm_pkg::ST_LIGHTEN) && (cnt_wide < tgt_pos)) ||
                        ((code == dbssm_pkg::ST_DARKEN) && (cnt_wide > tgt_pos));
               end
            end else if (is_handle) begin
               act = ((code == dbssm_pkg::ST_SHUT) &&
                      ((cur_ff == dbssm_pkg::ST_LOCKED) || (cur_ff == dbssm_pkg::ST_CLOSED))) ||
                     ((code == dbssm_pkg::ST_UNSHUT) &&
                      ((cur_ff == dbssm_pkg::ST_OPEN) || (cur_ff == dbssm_pkg::ST_TILT))) ||
                     ((code == dbssm_pkg::ST_UNLOCKED) && (cur_ff != dbssm_pkg::ST_LOCKED));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= dbssm_pkg::ST_OFF;
         prev_ff  <= dbssm_pkg::ST_OFF;
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
      end else if (fire) begin
         cur_ff   <= cur_in;
         prev_ff  <= prev_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign result.drive_mask = ({1'b0, cfg.output_slot} < 5'(dbssm_pkg::OUTPUT_SLOTS)) ?
                              ({7'd0, flags} << cfg.output_slot) : 9'd0;
   assign result.is_active  = act;
   assign result.level_now  = cur_in;

endmodule

/* rtl/dbssm_checker.sv */
// Port-level checker of the device controller and its bind
`include "dimmer_blind_switch_state_machine_core_assert.svh"

module dbssm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [8:0]  rsp_drive_mask,
   input logic        rsp_is_active,
   input logic [6:0]  rsp_level_now
);

   logic        rsp_held;
   logic        rsp_act_drive;
   logic [16:0] rsp_payload;

   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_act_drive = rsp_is_active && (rsp_drive_mask != 9'd0);
   assign rsp_payload   = {rsp_drive_mask, rsp_is_active, rsp_level_now};

   `DBSSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))
   `DBSSM_ASSERT_NOW(a_drive_xor_query, clock, reset, rsp_valid, !rsp_act_drive)
   `DBSSM_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   `DBSSM_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid && !req_stall)

endmodule

bind dimmer_blind_switch_state_machine_core dbssm_checker u_dbssm_checker (.*);

/* dv/dimmer_blind_switch_state_machine_core_test.sv */
// Self-checking testbench of the device controller: random requests, register settings, stalls
module dimmer_blind_switch_state_machine_core_test;
   import dbssm_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DELAY = 2'd1,
      PH_RAMP  = 2'd2
   } motion_phase_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [6:0]  req_state_code = '0;
   logic [15:0] req_elapsed_ticks = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [8:0]  rsp_drive_mask;
   logic        rsp_is_active;
   logic [6:0]  rsp_level_now;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   dimmer_blind_switch_state_machine_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_state_code    (req_state_code),
      .req_elapsed_ticks (req_elapsed_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_mask    (rsp_drive_mask),
      .rsp_is_active     (rsp_is_active),
      .rsp_level_now     (rsp_level_now),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mirror of the device registers and state
   logic [2:0]       kind_r = KIND_SWITCH;
   logic [23:0]      delay_r = '0;
   logic [23:0]      timeout_r = '0;
   logic [15:0]      speed_r = '0;
   logic [3:0]       slot_r = '0;
   logic [6:0]       level_cur = ST_OFF;
   logic [6:0]       level_prev = ST_OFF;
   motion_phase_type phase_now = PH_IDLE;
   longint           count_pos = 0;

   req_item_type queued_commands[$];
   rsp_item_type due_reports[$];
   int failures = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_run = 0;
   int stall_cycle = 0;

   function automatic longint level_pos(logic [6:0] lv);
      return longint'(lv) * 65536;
   endfunction

   function automatic logic [6:0] rounded_level(longint pos);
      longint v;
      v = pos + 32768;
      if (v < 0) return ST_OFF;
      return 7'(v / 65536);
   endfunction

   function automatic bit ramp_kind();
      return kind_r == KIND_DIMMER || kind_r == KIND_BLIND;
   endfunction

   function automatic logic answer_query(logic [6:0] code);
      longint s;
      s = level_pos(level_cur);
      if (code == level_cur) return 1'b1;
      if (ramp_kind()) begin
         if (phase_now == PH_IDLE) return code == ST_STOP;
         return code == ST_DIM || (code == ST_LIGHTEN && count_pos < s) ||
                (code == ST_DARKEN && count_pos > s);
      end
      if (kind_r == KIND_HANDLE)
         return (code == ST_SHUT && (level_cur == ST_LOCKED || level_cur == ST_CLOSED)) ||
                (code == ST_UNSHUT && (level_cur == ST_OPEN || level_cur == ST_TILT)) ||
                (code == ST_UNLOCKED && level_cur != ST_LOCKED);
      return 1'b0;
   endfunction

   function automatic void apply_setting(logic [6:0] code);
      logic [6:0] cur;
      logic [6:0] goal;
      cur = level_cur;
      goal = code;
      if (kind_r == KIND_SWITCH || kind_r == KIND_LIGHT) begin
         level_prev = cur;
         level_cur = code;
         phase_now = PH_DELAY;
         count_pos = longint'(delay_r);
         return;
      end
      if (kind_r == KIND_HANDLE) begin
         level_prev = cur;
         level_cur = code;
         return;
      end
      if (!ramp_kind()) return;
      if (kind_r == KIND_DIMMER && (code == ST_OFF || code == ST_ON)) begin
         level_prev = cur;
         level_cur = code;
         phase_now = PH_IDLE;
         count_pos = longint'(timeout_r);
         return;
      end
      if (code == ST_STOP || phase_now == PH_RAMP) begin
         if (phase_now == PH_RAMP) begin
            level_cur = rounded_level(count_pos);
            phase_now = PH_IDLE;
         end
         return;
      end
      if (code == ST_DIM)
         goal = ((level_prev > cur && cur < ST_ON) || cur == ST_OFF) ? ST_ON : ST_OFF;
      else if (code == ST_LIGHTEN)
         goal = ST_ON;
      else if (code == ST_DARKEN)
         goal = ST_OFF;
      level_prev = cur;
      level_cur = goal;
      phase_now = PH_RAMP;
      count_pos = level_pos(cur);
   endfunction

   function automatic logic [8:0] apply_ticks(logic [15:0] ticks);
      logic [6:0] cur;
      logic [1:0] flags;
      longint     s;
      longint     stride;
      cur = level_cur;
      flags = 2'd0;
      if (kind_r == KIND_SWITCH || kind_r == KIND_LIGHT) begin
         if (phase_now == PH_DELAY) begin
            count_pos -= longint'(ticks);
            if (count_pos <= 0) begin
               phase_now = PH_IDLE;
               count_pos = longint'(timeout_r);
            end
         end else if (count_pos > 0) begin
            count_pos -= longint'(ticks);
            if (count_pos <= 0) begin
               level_prev = cur;
               level_cur = ST_OFF;
            end
         end
         flags = (((phase_now == PH_DELAY) ? level_prev : cur) == ST_ON) ? 2'd1 : 2'd0;
      end else if (ramp_kind()) begin
         if (phase_now == PH_RAMP) begin
            s = level_pos(cur);
            stride = longint'(ticks) * longint'(speed_r);
            if (count_pos < s) begin
               count_pos += stride;
               if (count_pos > s) count_pos = s;
               flags = 2'd1;
            end else begin
               count_pos -= stride;
               if (count_pos < s) count_pos = s;
               flags = 2'd2;
            end
            if (speed_r == 16'd0 || count_pos == s) begin
               phase_now = PH_IDLE;
               flags = 2'd0;
               count_pos = longint'(timeout_r);
            end
         end else if (count_pos > 0) begin
            count_pos -= longint'(ticks);
            if (count_pos <= 0) begin
               level_prev = cur;
               level_cur = ST_OFF;
               count_pos = level_pos(cur);
            end
         end
      end
      if (slot_r < OUTPUT_SLOTS) return 9'(flags) << slot_r;
      return 9'd0;
   endfunction

   function automatic rsp_item_type device_step(req_item_type cmd);
      rsp_item_type r;
      r = '0;
      case (cmd.opcode)
         OP_SET:   apply_setting(cmd.state_code);
         OP_TICK:  r.drive_mask = apply_ticks(cmd.elapsed_ticks);
         OP_QUERY: r.is_active = answer_query(cmd.state_code);
         default: ;
      endcase
      r.level_now = level_cur;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            due_reports.push_back(device_step({req_opcode, req_state_code, req_elapsed_ticks}));
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_commands.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               {req_opcode, req_state_code, req_elapsed_ticks} <= queued_commands.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25)
                                                         : $urandom_range(1, 4);
               end
            end
         end
      end
   end

   // response monitor and stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_reports.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected response: drive_mask %0h is_active %0d level_now %0d",
                           rsp_drive_mask, rsp_is_active, rsp_level_now);
            end else begin
               rsp_item_type want;
               want = due_reports.pop_front();
               if (rsp_drive_mask !== want.drive_mask || rsp_is_active !== want.is_active ||
                   rsp_level_now !== want.level_now) begin
                  failures++;
                  if (failures <= 10)
                     $display("mismatch exp/act: drive_mask %0h/%0h is_active %0d/%0d %s %0d/%0d",
                              want.drive_mask, rsp_drive_mask, want.is_active, rsp_is_active,
                              "level_now", want.level_now, rsp_level_now);
               end
            end
         end
         stall_cycle++;
         case ((stall_cycle / 300) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: begin
               if (stall_run > 0) begin
                  stall_run--;
                  rsp_stall <= 1'b1;
               end else if ($urandom_range(0, 9) == 0) begin
                  stall_run = $urandom_range(1, 12);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
            default: rsp_stall <= stall_cycle[0];
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic push_cmd(logic [1:0] op, logic [6:0] code, logic [15:0] ticks);
      queued_commands.push_back({op, code, ticks});
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic program_device(logic [2:0] kind, logic [23:0] delay_val,
                                 logic [23:0] timeout_val, logic [15:0] speed,
                                 logic [3:0] slot);
      write_reg(CSR_DEVICE_KIND, 24'(kind));
      write_reg(CSR_DELAY_TICKS, delay_val);
      write_reg(CSR_TIMEOUT_TICKS, timeout_val);
      write_reg(CSR_RAMP_SPEED, 24'(speed));
      write_reg(CSR_OUTPUT_SLOT, 24'(slot));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      kind_r = kind;
      delay_r = delay_val;
      timeout_r = timeout_val;
      speed_r = speed;
      slot_r = slot;
   endtask

   // hold until every request is answered, then let the pipeline go quiet
   task automatic settle();
      do @(negedge clock);
      while (queued_commands.size() != 0 || req_valid || due_reports.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [23:0] pick_span();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(1000, 50000));
         default: return 24'($urandom_range(1, 60));
      endcase
   endfunction

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 255));
         3: return 16'($urandom);
         default: return 16'($urandom_range(4096, 40000));
      endcase
   endfunction

   function automatic logic [6:0] pick_target();
      int r;
      r = $urandom_range(0, 9);
      if (ramp_kind()) begin
         if (r == 0) return ST_OFF;
         if (r == 1) return ST_ON;
         if (r <= 5) return 7'($urandom_range(0, 100));
         if (r <= 8) return 7'($urandom_range(101, 104));
         return 7'($urandom_range(105, 111));
      end
      if (kind_r == KIND_HANDLE)
         return (r < 8) ? 7'($urandom_range(105, 111)) : 7'($urandom_range(0, 111));
      if (r < 3) return ST_OFF;
      if (r < 7) return ST_ON;
      return 7'($urandom_range(0, 111));
   endfunction

   function automatic logic [6:0] pick_query(logic [6:0] target);
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return target;
      if (r < 7) return 7'($urandom_range(101, 111));
      return 7'($urandom_range(0, 111));
   endfunction

   function automatic logic [15:0] pick_ticks();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 16'($urandom_range(0, 15));
      if (r < 18) return 16'($urandom_range(0, 1000));
      if (r == 18) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   task automatic queue_random_commands(int count);
      int left;
      int steps;
      logic [6:0] target;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 99) < 10) begin
            push_cmd(2'($urandom_range(0, 3)), 7'($urandom_range(0, 111)), 16'($urandom));
            left--;
         end else begin
            target = pick_target();
            push_cmd(OP_SET, target, 16'($urandom));
            steps = $urandom_range(1, 8);
            for (int k = 0; k < steps; k++) begin
               case ($urandom_range(0, 9))
                  0, 1: push_cmd(OP_QUERY, pick_query(target), 16'($urandom));
                  2: push_cmd(OP_SET, ST_STOP, 16'($urandom));
                  default: push_cmd(OP_TICK, 7'($urandom_range(0, 111)), pick_ticks());
               endcase
            end
            left -= steps + 1;
         end
      end
   endtask

   initial begin
      logic [2:0] kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // switch at reset settings, spare opcode, field extremes
      push_cmd(OP_SET, ST_ON, 16'd0);
      push_cmd(OP_TICK, ST_OFF, 16'd0);
      push_cmd(OP_QUERY, ST_ON, 16'hFFFF);
      push_cmd(OP_SPARE, ST_UNLOCKED, 16'hFFFF);
      push_cmd(OP_QUERY, ST_UNLOCKED, 16'd0);
      settle();

      // dimmer: ramp, stop rounding, toggle, direct level, timeout, non-level target
      program_device(KIND_DIMMER, 24'd0, 24'd3, 16'h6000, 4'd7);
      push_cmd(OP_SET, 7'd50, 16'd0);
      push_cmd(OP_QUERY, ST_DARKEN, 16'd0);
      push_cmd(OP_TICK, ST_OFF, 16'd3);
      push_cmd(OP_SET, ST_STOP, 16'd0);
      push_cmd(OP_SET, ST_DIM, 16'd0);
      push_cmd(OP_TICK, ST_OFF, 16'hFFFF);
      push_cmd(OP_SET, ST_ON, 16'd0);
      push_cmd(OP_TICK, ST_OFF, 16'd2);
      push_cmd(OP_TICK, ST_OFF, 16'd2);
      push_cmd(OP_SET, ST_OPEN, 16'd0);
      push_cmd(OP_QUERY, ST_LIGHTEN, 16'd0);
      settle();

      // blind at zero speed with the slot beyond the count
      program_device(KIND_BLIND, 24'd0, 24'd0, 16'd0, 4'd12);
      push_cmd(OP_SET, 7'd30, 16'd0);
      push_cmd(OP_TICK, ST_OFF, 16'd5);
      settle();

      // unused kind, then handle
      program_device(3'd6, 24'd0, 24'd0, 16'd0, 4'd0);
      push_cmd(OP_SET, 7'd40, 16'd0);
      push_cmd(OP_QUERY, 7'd30, 16'd0);
      settle();
      program_device(KIND_HANDLE, 24'd0, 24'd0, 16'd0, 4'd0);
      push_cmd(OP_SET, ST_LOCKED, 16'd0);
      push_cmd(OP_QUERY, ST_SHUT, 16'd0);
      push_cmd(OP_QUERY, ST_UNLOCKED, 16'd0);
      push_cmd(OP_SET, ST_TILT, 16'd0);
      push_cmd(OP_QUERY, ST_UNSHUT, 16'd0);
      settle();

      for (int p = 0; p < 12; p++) begin
         case (p)
            0: program_device(KIND_HANDLE, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 4'd15);
            1: program_device(KIND_SWITCH, 24'd0, 24'd0, 16'd0, 4'd0);
            2: program_device(KIND_DIMMER, 24'd5, 24'hFFFFFF, 16'hFFFF, 4'd7);
            3: program_device(KIND_BLIND, 24'd0, 24'd0, 16'd1, 4'd1);
            4: program_device(KIND_LIGHT, 24'hFFFFFF, 24'd20, 16'd0, 4'd3);
            default: begin
               kind = ($urandom_range(0, 15) < 14) ? 3'($urandom_range(0, 4))
                                                   : 3'($urandom_range(5, 7));
               program_device(kind, pick_span(), pick_span(), pick_speed(),
                              ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
                                                          : 4'($urandom_range(0, 7)));
            end
         endcase
         queue_random_commands(162);
         settle();
      end

      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
